/* src/gbpa_pkg.sv */
// ----------------------------------------------------------------------------
// gbpa_pkg
// Shared types and constants of the growable block pool allocator.
// ----------------------------------------------------------------------------
package gbpa_pkg;

   // Default geometry of the pool
   localparam int DEF_SLOTS   = 256;
   localparam int DEF_RESERVE = 128;

   // Slot flags held by one cell of the search chain
   localparam int CELL_BITS = 16;

   // Configuration port
   localparam int CFG_W     = 9;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] REG_PRE_ALLOC = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_SLOTS = 1'd1;

   // Operation codes
   localparam logic OP_GET     = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Status codes
   localparam logic [1:0] STAT_OK          = 2'd0;
   localparam logic [1:0] STAT_EXHAUSTED   = 2'd1;
   localparam logic [1:0] STAT_BAD_RELEASE = 2'd2;

   typedef struct packed {
      logic       op;
      logic [7:0] slot_in;
   } req_word_type;

   typedef struct packed {
      logic [7:0] slot_out;
      logic [1:0] status;
   } rsp_word_type;

   // Flag update broadcast to every cell
   typedef struct packed {
      logic fill;   // restart: every slot free
      logic clr;    // mark the addressed slot used
      logic set;    // mark the addressed slot free
   } cell_cmd_type;

   // Search token handed from cell to cell
   typedef struct packed {
      logic found;  // a free slot below the pool count was seen
      logic used;   // the queried slot was seen used
   } tok_flags_type;

endpackage

/* src/growable_block_pool_allocator.sv */
// ----------------------------------------------------------------------------
// growable_block_pool_allocator
// Hands out and takes back slot indices of a pool of equal-sized blocks.
// ----------------------------------------------------------------------------
// A get request (op 0) returns the lowest free slot below the pool count and
// marks it used; with no free slot the pool grows by one used slot while it
// is under the limit (max_slots, 0 = up to SLOTS), else status 1 comes back.
// A release (op 1) frees a used slot below the pool count; anything else
// answers status 2 and changes nothing. Every request gives exactly one
// response word. The slot flags sit in a chain of NCELL = ceil(SLOTS/16)
// cells of 16 flags each; a search token walks the chain one cell per cycle,
// and a request is committed to the response register once the token has
// crossed the whole chain; the next request is taken in the cycle after the
// commit. One request is in work at a time. The response sits in an output
// register, so a stalled response does not block acceptance of the next
// request; that request's commit waits until the register is free. Writing
// pre_alloc or max_slots restarts the pool: all flags set free and the pool
// count reloaded; write only while idle.
// ----------------------------------------------------------------------------
module growable_block_pool_allocator #(
   parameter int SLOTS   = gbpa_pkg::DEF_SLOTS,
   parameter int RESERVE = gbpa_pkg::DEF_RESERVE
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  gbpa_pkg::req_word_type         req_word,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output gbpa_pkg::rsp_word_type         rsp_word,
   // configuration
   input  logic                           csr_wr_en,
   input  logic [gbpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gbpa_pkg::CFG_W-1:0]     csr_wdata
);
   import gbpa_pkg::*;

   localparam int NCELL  = (SLOTS + CELL_BITS - 1) / CELL_BITS;
   localparam int POS_W  = $clog2(NCELL * CELL_BITS + 1);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int QRY_W  = (POS_W > 8) ? POS_W : 8;
   localparam int WIDE_W = QRY_W;
   localparam int RSV_W  = $clog2(RESERVE + 1);
   localparam int CALC_A = (RSV_W > CNT_W) ? RSV_W : CNT_W;
   localparam int CALC_W = (CALC_A > CFG_W) ? CALC_A : CFG_W;
   localparam int TMR_W  = $clog2(NCELL + 1);
   localparam int RESET_COUNT = (RESERVE < SLOTS) ? RESERVE : SLOTS;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_SEARCH = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [TMR_W-1:0]   tmr_ff, tmr_in;
   logic               op_ff, op_in;
   logic [QRY_W-1:0]   query_ff, query_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CFG_W-1:0]   pre_ff, pre_in;
   logic [CFG_W-1:0]   max_ff, max_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   cell_cmd_type       cmd;
   logic [POS_W-1:0]   wr_idx;
   logic [POS_W-1:0]   count_pos;
   tok_flags_type      tok_flags [NCELL+1];
   logic [POS_W-1:0]   tok_idx   [NCELL+1];

   logic               cfg_wr;
   logic               done;
   logic               grow_ok;
   logic               rel_ok;
   logic [CALC_W-1:0]  start_calc;
   logic [WIDE_W-1:0]  grant_wide;
   logic [WIDE_W-1:0]  grow_wide;

   assign count_pos = POS_W'(count_ff);
   assign cfg_wr    = csr_wr_en && ((csr_index == REG_PRE_ALLOC) || (csr_index == REG_MAX_SLOTS));

   // Chain of flag cells; cell 0 sees an empty token
   assign tok_flags[0] = '0;
   assign tok_idx[0]   = '0;

   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      gbpa_cell #(
         .BASE  (k * CELL_BITS),
         .SLOTS (SLOTS),
         .POS_W (POS_W),
         .QRY_W (QRY_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .wr_idx     (wr_idx),
         .pool_count (count_pos),
         .query      (query_ff),
         .prev_flags (tok_flags[k]),
         .prev_idx   (tok_idx[k]),
         .next_flags (tok_flags[k+1]),
         .next_idx   (tok_idx[k+1])
      );
   end

   // Starting pool size from the new register values
   always_comb begin
      pre_in = pre_ff;
      max_in = max_ff;
      if (csr_wr_en && (csr_index == REG_PRE_ALLOC)) pre_in = csr_wdata;
      if (csr_wr_en && (csr_index == REG_MAX_SLOTS)) max_in = csr_wdata;
      start_calc = CALC_W'(RESERVE);
      if (CALC_W'(pre_in) > start_calc) start_calc = CALC_W'(pre_in);
      if ((max_in != '0) && (CALC_W'(max_in) < start_calc)) start_calc = CALC_W'(max_in);
      if (start_calc > CALC_W'(SLOTS)) start_calc = CALC_W'(SLOTS);
   end

   // Commit once the token has crossed the whole chain and the output
   // register is free
   assign done    = (state_ff == ST_SEARCH) && (tmr_ff == '0) && (!rsp_valid_ff || !rsp_stall);
   assign grow_ok = (CALC_W'(count_ff) < CALC_W'(SLOTS)) &&
                    ((max_ff == '0) || (CALC_W'(count_ff) < CALC_W'(max_ff)));
   assign rel_ok  = (query_ff < QRY_W'(count_ff)) && tok_flags[NCELL].used;

   assign grant_wide = WIDE_W'(tok_idx[NCELL]);
   assign grow_wide  = WIDE_W'(count_ff);

   always_comb begin
      state_in     = state_ff;
      tmr_in       = tmr_ff;
      op_in        = op_ff;
      query_in     = query_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      cmd          = '0;
      wr_idx       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_word.op;
               query_in = QRY_W'(req_word.slot_in);
               tmr_in   = TMR_W'(NCELL);
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (tmr_ff != '0) begin
               tmr_in = tmr_ff - 1'b1;
            end else if (done) begin
               rsp_valid_in         = 1'b1;
               rsp_word_in.slot_out = '0;
               rsp_word_in.status   = STAT_OK;
               state_in             = ST_IDLE;
               if (op_ff == OP_GET) begin
                  if (tok_flags[NCELL].found) begin
                     cmd.clr              = 1'b1;
                     wr_idx               = tok_idx[NCELL];
                     rsp_word_in.slot_out = grant_wide[7:0];
                  end else if (grow_ok) begin
                     cmd.clr              = 1'b1;
                     wr_idx               = count_pos;
                     count_in             = count_ff + 1'b1;
                     rsp_word_in.slot_out = grow_wide[7:0];
                  end else begin
                     rsp_word_in.status = STAT_EXHAUSTED;
                  end
               end else begin
                  if (rel_ok) begin
                     cmd.set = 1'b1;
                     wr_idx  = query_ff[POS_W-1:0];
                  end else begin
                     rsp_word_in.status = STAT_BAD_RELEASE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Restart the pool on a register write
      if (cfg_wr) begin
         cmd      = '0;
         cmd.fill = 1'b1;
         count_in = CNT_W'(start_calc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tmr_ff       <= '0;
         count_ff     <= CNT_W'(RESET_COUNT);
         pre_ff       <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tmr_ff       <= tmr_in;
         count_ff     <= count_in;
         pre_ff       <= pre_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: hold while stalled
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      query_ff    <= query_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* src/gbpa_cell.sv */
// ----------------------------------------------------------------------------
// gbpa_cell
// One cell of the search chain: holds a group of slot flags, finds the
// lowest free one of the group and passes the search token to its neighbor.
// ----------------------------------------------------------------------------
module gbpa_cell #(
   parameter int BASE  = 0,
   parameter int SLOTS = gbpa_pkg::DEF_SLOTS,
   parameter int POS_W = 9,
   parameter int QRY_W = 9
) (
   input  logic                    clock,
   input  logic                    reset,
   input  gbpa_pkg::cell_cmd_type  cmd,
   input  logic [POS_W-1:0]        wr_idx,
   input  logic [POS_W-1:0]        pool_count,
   input  logic [QRY_W-1:0]        query,
   input  gbpa_pkg::tok_flags_type prev_flags,
   input  logic [POS_W-1:0]        prev_idx,
   output gbpa_pkg::tok_flags_type next_flags,
   output logic [POS_W-1:0]        next_idx
);
   import gbpa_pkg::*;

   logic [CELL_BITS-1:0] free_ff;
   logic [CELL_BITS-1:0] free_in;
   tok_flags_type        flags_ff;
   tok_flags_type        flags_in;
   logic [POS_W-1:0]     idx_ff;
   logic [POS_W-1:0]     idx_in;
   logic                 local_found;
   logic                 local_used;
   logic [POS_W-1:0]     local_idx;

   // Lowest free slot of the group, and the state of the queried slot
   always_comb begin
      local_found = 1'b0;
      local_used  = 1'b0;
      local_idx   = '0;
      for (int j = CELL_BITS - 1; j >= 0; j--) begin
         if (free_ff[j] && (POS_W'(BASE + j) < pool_count) && ((BASE + j) < SLOTS)) begin
            local_found = 1'b1;
            local_idx   = POS_W'(BASE + j);
         end
      end
      for (int j = 0; j < CELL_BITS; j++) begin
         if ((query == QRY_W'(BASE + j)) && ((BASE + j) < SLOTS) && !free_ff[j]) begin
            local_used = 1'b1;
         end
      end
   end

   // Keep the first hit from upstream, else take this group's
   always_comb begin
      flags_in.found = prev_flags.found | local_found;
      flags_in.used  = prev_flags.used | local_used;
      idx_in         = prev_flags.found ? prev_idx : local_idx;
   end

   always_comb begin
      free_in = free_ff;
      if (cmd.fill) begin
         free_in = '1;
      end else begin
         for (int j = 0; j < CELL_BITS; j++) begin
            if (wr_idx == POS_W'(BASE + j)) begin
               if (cmd.clr) free_in[j] = 1'b0;
               if (cmd.set) free_in[j] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff  <= '1;
         flags_ff <= '0;
      end else begin
         free_ff  <= free_in;
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   assign next_flags = flags_ff;
   assign next_idx   = idx_ff;

endmodule

/* src/gbpa_checker.sv */
// ----------------------------------------------------------------------------
// gbpa_checker
// Port-level checks of the growable block pool allocator.
// ----------------------------------------------------------------------------
module gbpa_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input gbpa_pkg::req_word_type         req_word,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input gbpa_pkg::rsp_word_type         rsp_word,
   input logic                           csr_wr_en,
   input logic [gbpa_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [gbpa_pkg::CFG_W-1:0]     csr_wdata
);
   import gbpa_pkg::*;

   // Hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.status == STAT_OK) || (rsp_word.status == STAT_EXHAUSTED) ||
                    (rsp_word.status == STAT_BAD_RELEASE))
      else $error("undefined status code");

   a_fail_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status != STAT_OK) |-> rsp_word.slot_out == 8'd0)
      else $error("failed request reports a slot");

   // The search is registered: an accepted request gets no immediate response
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("response appeared one cycle after a request");

endmodule

bind growable_block_pool_allocator gbpa_checker u_gbpa_checker (.*);
